// File: sv/vtpg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vtpg_pkg;

    // cordic geometry
    localparam int CORDIC_STEPS = 15;
    localparam int ROT_W        = 27;   // rotation lane x/y width
    localparam int ANG_W        = 18;   // rotation lane residual angle width
    localparam int VEC_W        = 27;   // vectoring lane x/y width

    // arctangent of 2^-i in units of 1/65536 turn
    localparam logic [15:0] ATAN_TURNS [0:CORDIC_STEPS-1] = '{
        16'd8192, 16'd4836, 16'd2555, 16'd1297, 16'd651, 16'd326, 16'd163, 16'd81,
        16'd41, 16'd20, 16'd10, 16'd5, 16'd3, 16'd1, 16'd1
    };

    // gain-compensated start value of the rotation lanes
    localparam logic signed [ROT_W-1:0] CORDIC_START_X = 27'sd10188032;

    // fixed point constants
    localparam logic [29:0] INV_2PI_Q32 = 30'd683565276;
    localparam logic [15:0] VALUE_Q16   = 16'd52429;

    // register map
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_PAUSED_MODE  = 2'd2;
    localparam logic [1:0] REG_TIME_PHASE   = 2'd3;

    // one colour before byte conversion, Q.16
    typedef struct packed {
        logic [16:0] red;
        logic [16:0] green;
        logic [16:0] blue;
    } color_t;

endpackage

`default_nettype wire

// File: sv/vtpg_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module vtpg_div_cell #(
    parameter int RW = 10
) (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire logic [RW-1:0] divisor,
    input  wire logic [RW-1:0] rem_in,
    input  wire logic [15:0]   quo_in,
    output logic      [RW-1:0] rem_out,
    output logic      [15:0]   quo_out
);

    logic [RW:0] rem_dbl;
    logic        take;

    // one restoring quotient bit
    assign rem_dbl = {rem_in, 1'b0};
    assign take    = (rem_dbl >= {1'b0, divisor});

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_out <= take ? RW'(rem_dbl - {1'b0, divisor}) : rem_dbl[RW-1:0];
            quo_out <= {quo_in[14:0], take};
        end
    end

endmodule

`default_nettype wire

// File: sv/vtpg_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module vtpg_sqrt_cell (
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic [31:0] val_in,
    input  wire logic [16:0] rem_in,
    input  wire logic [15:0] root_in,
    output logic      [31:0] val_out,
    output logic      [16:0] rem_out,
    output logic      [15:0] root_out
);

    logic [18:0] rem_sh;
    logic [18:0] trial;
    logic        take;

    // one root bit per cell, two radicand bits shifted in
    assign rem_sh = {rem_in, val_in[31:30]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge aclk) begin
        if (en) begin
            val_out  <= {val_in[29:0], 2'b00};
            rem_out  <= take ? 17'(rem_sh - trial) : rem_sh[16:0];
            root_out <= {root_in[14:0], take};
        end
    end

endmodule

`default_nettype wire

// File: sv/vtpg_rot_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module vtpg_rot_cell #(
    parameter int STEP = 0
) (
    input  wire logic                                   aclk,
    input  wire logic                                   en,
    input  wire logic signed [vtpg_pkg::ROT_W-1:0]      x_in,
    input  wire logic signed [vtpg_pkg::ROT_W-1:0]      y_in,
    input  wire logic signed [vtpg_pkg::ANG_W-1:0]      a_in,
    output logic      signed [vtpg_pkg::ROT_W-1:0]      x_out,
    output logic      signed [vtpg_pkg::ROT_W-1:0]      y_out,
    output logic      signed [vtpg_pkg::ANG_W-1:0]      a_out
);

    localparam logic signed [vtpg_pkg::ANG_W-1:0] ANG =
        $signed({{(vtpg_pkg::ANG_W-16){1'b0}}, vtpg_pkg::ATAN_TURNS[STEP]});

    logic signed [vtpg_pkg::ROT_W-1:0] dx;
    logic signed [vtpg_pkg::ROT_W-1:0] dy;

    assign dx = x_in >>> STEP;
    assign dy = y_in >>> STEP;

    // rotate toward zero residual angle
    always_ff @(posedge aclk) begin
        if (en) begin
            if (a_in >= 0) begin
                x_out <= x_in - dy;
                y_out <= y_in + dx;
                a_out <= a_in - ANG;
            end else begin
                x_out <= x_in + dy;
                y_out <= y_in - dx;
                a_out <= a_in + ANG;
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/vtpg_vec_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module vtpg_vec_cell #(
    parameter int STEP = 0
) (
    input  wire logic                              aclk,
    input  wire logic                              en,
    input  wire logic signed [vtpg_pkg::VEC_W-1:0] x_in,
    input  wire logic signed [vtpg_pkg::VEC_W-1:0] y_in,
    input  wire logic        [15:0]                z_in,
    output logic      signed [vtpg_pkg::VEC_W-1:0] x_out,
    output logic      signed [vtpg_pkg::VEC_W-1:0] y_out,
    output logic             [15:0]                z_out
);

    logic signed [vtpg_pkg::VEC_W-1:0] dx;
    logic signed [vtpg_pkg::VEC_W-1:0] dy;

    assign dx = x_in >>> STEP;
    assign dy = y_in >>> STEP;

    // drive y toward zero, accumulate the angle in turns
    always_ff @(posedge aclk) begin
        if (en) begin
            if (y_in >= 0) begin
                x_out <= x_in + dy;
                y_out <= y_in - dx;
                z_out <= z_in + vtpg_pkg::ATAN_TURNS[STEP];
            end else begin
                x_out <= x_in - dy;
                y_out <= y_in + dx;
                z_out <= z_in - vtpg_pkg::ATAN_TURNS[STEP];
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/video_test_pattern_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// Video test pattern generator: one pixel coordinate in, one RGBA colour out.
// Input channel s_* carries pixel_x / pixel_y, result channel m_* carries
// red / green / blue / alpha (alpha is always 255). Both are valid/ready.
// The APB port sets frame width, frame height, paused mode (colour wheel)
// and the animation time; write it only while no pixel is in flight.
// Throughput is one pixel per clock while the skid register is empty. Each
// pixel passes one input stage, a 16-cell divider chain for the
// coordinate normalization, then 20 stages of cordic, square root and
// multiply cells; both patterns are computed in parallel and one is picked.
// When the receiver stalls, the output register holds its pixel and a skid
// register catches the next one; the chain then freezes and s_ready drops
// until the skid register drains.
// Reset clears the pipeline and loads 640 x 360, wave mode, time zero.
module video_test_pattern_generator #(
    parameter int MAX_WIDTH  = 640,
    parameter int MAX_HEIGHT = 360
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [9:0]  s_pixel_x,
    input  wire logic [8:0]  s_pixel_y,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [7:0]  m_red,
    output logic      [7:0]  m_green,
    output logic      [7:0]  m_blue,
    output logic      [7:0]  m_alpha
);

    localparam int RW    = vtpg_pkg::ROT_W;
    localparam int AW    = vtpg_pkg::ANG_W;
    localparam int VW    = vtpg_pkg::VEC_W;
    localparam int STEPS = vtpg_pkg::CORDIC_STEPS;
    localparam int LANES = 5;
    localparam int LAST  = 36;

    localparam logic [15:0] LANE_OFFSET [0:LANES-1] = '{
        16'd0, 16'd16384, 16'd16384, 16'd10923, 16'd21845
    };

    function automatic logic signed [AW-1:0] fold_turns(input logic [15:0] ph);
        logic signed [AW-1:0] a;
        a = AW'($signed(ph));
        if (a > 18'sd16384) begin
            a = 18'sd32768 - a;
        end else if (a < -18'sd16384) begin
            a = -18'sd32768 - a;
        end
        return a;
    endfunction

    function automatic logic [16:0] half_up(input logic signed [18:0] s);
        logic signed [20:0] h;
        h = (21'(s) + 21'sd65536) >>> 1;
        if (h < 0) begin
            return 17'd0;
        end
        if (h > 21'sd65536) begin
            return 17'd65536;
        end
        return h[16:0];
    endfunction

    function automatic logic [7:0] to_byte(input logic [16:0] v);
        logic [24:0] m;
        m = 25'(v) * 25'd255;
        return (m[24:16] > 9'd255) ? 8'd255 : m[23:16];
    endfunction

    // configuration registers
    logic [9:0]  width_reg;
    logic [8:0]  height_reg;
    logic        paused_reg;
    logic [31:0] time_reg;
    logic        cfg_write;

    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 10'd640;
            height_reg <= 9'd360;
            paused_reg <= 1'b0;
            time_reg   <= 32'd0;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                vtpg_pkg::REG_FRAME_WIDTH:  width_reg  <= pwdata[9:0];
                vtpg_pkg::REG_FRAME_HEIGHT: height_reg <= pwdata[8:0];
                vtpg_pkg::REG_PAUSED_MODE:  paused_reg <= pwdata[0];
                vtpg_pkg::REG_TIME_PHASE:   time_reg   <= pwdata;
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (paddr[3:2])
            vtpg_pkg::REG_FRAME_WIDTH:  prdata = {22'd0, width_reg};
            vtpg_pkg::REG_FRAME_HEIGHT: prdata = {23'd0, height_reg};
            vtpg_pkg::REG_PAUSED_MODE:  prdata = {31'd0, paused_reg};
            vtpg_pkg::REG_TIME_PHASE:   prdata = time_reg;
            default:                    prdata = 32'd0;
        endcase
    end

    // effective frame size
    logic [9:0] w_eff;
    logic [8:0] h_eff;

    always_comb begin
        if (width_reg == 10'd0) begin
            w_eff = 10'd1;
        end else if (32'(width_reg) > MAX_WIDTH) begin
            w_eff = 10'(MAX_WIDTH);
        end else begin
            w_eff = width_reg;
        end
        if (height_reg == 9'd0) begin
            h_eff = 9'd1;
        end else if (32'(height_reg) > MAX_HEIGHT) begin
            h_eff = 9'(MAX_HEIGHT);
        end else begin
            h_eff = height_reg;
        end
    end

    // pipeline control: the chain moves unless the skid register is full
    logic            en;
    logic [LAST:0]   vld_reg;
    logic            skid_vld_reg;

    assign en      = !skid_vld_reg;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAST-1:0], s_valid};
        end
    end

    // input stage with clamp to the active frame
    logic [9:0] px_reg;
    logic [8:0] py_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg <= (s_pixel_x >= w_eff) ? 10'(w_eff - 10'd1) : s_pixel_x;
            py_reg <= (s_pixel_y >= h_eff) ? 9'(h_eff - 9'd1) : s_pixel_y;
        end
    end

    // coordinate normalization, one quotient bit per cell
    logic [9:0]  dx_rem [0:16];
    logic [15:0] dx_quo [0:16];
    logic [8:0]  dy_rem [0:16];
    logic [15:0] dy_quo [0:16];

    assign dx_rem[0] = px_reg;
    assign dx_quo[0] = 16'd0;
    assign dy_rem[0] = py_reg;
    assign dy_quo[0] = 16'd0;

    for (genvar k = 0; k < 16; k++) begin : g_div
        vtpg_div_cell #(.RW(10)) u_div_x (
            .aclk    (aclk),
            .en      (en),
            .divisor (w_eff),
            .rem_in  (dx_rem[k]),
            .quo_in  (dx_quo[k]),
            .rem_out (dx_rem[k+1]),
            .quo_out (dx_quo[k+1])
        );
        vtpg_div_cell #(.RW(9)) u_div_y (
            .aclk    (aclk),
            .en      (en),
            .divisor (h_eff),
            .rem_in  (dy_rem[k]),
            .quo_in  (dy_quo[k]),
            .rem_out (dy_rem[k+1]),
            .quo_out (dy_quo[k+1])
        );
    end

    logic [15:0] nx;
    logic [15:0] ny;

    assign nx = dx_quo[16];
    assign ny = dy_quo[16];

    // ---------------- wave pattern ----------------

    // radian arguments of the five sine lanes
    logic [33:0] rad_reg [0:LANES-1];
    logic [47:0] t_mul_r;
    logic [47:0] t_mul_b;

    assign t_mul_r = 48'(time_reg) * 48'd19661;
    assign t_mul_b = 48'(time_reg) * 48'd45875;

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg[0] <= 34'(nx) * 34'd6 + 34'(time_reg);
            rad_reg[1] <= 34'(ny) * 34'd6 + 34'(time_reg) + 34'(time_reg >> 1);
            rad_reg[2] <= 34'(t_mul_r[47:16]);
            rad_reg[3] <= 34'(time_reg >> 1);
            rad_reg[4] <= 34'(t_mul_b[47:16]);
        end
    end

    // radians to turns, plus the lane phase offset
    logic [15:0] turn_reg [0:LANES-1];
    logic signed [RW-1:0] rx [0:LANES-1][0:STEPS];
    logic signed [RW-1:0] ry [0:LANES-1][0:STEPS];
    logic signed [AW-1:0] ra [0:LANES-1][0:STEPS];
    logic [16:0]          hu_reg [0:LANES-1];

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic [63:0] turn_prod;

        assign turn_prod = 64'(rad_reg[l]) * 64'(vtpg_pkg::INV_2PI_Q32);

        always_ff @(posedge aclk) begin
            if (en) begin
                turn_reg[l] <= turn_prod[47:32] + LANE_OFFSET[l];
            end
        end

        assign rx[l][0] = vtpg_pkg::CORDIC_START_X;
        assign ry[l][0] = '0;
        assign ra[l][0] = fold_turns(turn_reg[l]);

        for (genvar k = 0; k < STEPS; k++) begin : g_rot
            vtpg_rot_cell #(.STEP(k)) u_rot (
                .aclk  (aclk),
                .en    (en),
                .x_in  (rx[l][k]),
                .y_in  (ry[l][k]),
                .a_in  (ra[l][k]),
                .x_out (rx[l][k+1]),
                .y_out (ry[l][k+1]),
                .a_out (ra[l][k+1])
            );
        end

        // sine to a 0..1 weight
        always_ff @(posedge aclk) begin
            if (en) begin
                hu_reg[l] <= half_up(19'(ry[l][STEPS] >>> 8));
            end
        end
    end

    // wave product, then colour terms
    logic [16:0] wave_reg;
    logic [16:0] cr_reg;
    logic [16:0] cg_reg;
    logic [16:0] cb_reg;
    logic [33:0] wave_prod;

    assign wave_prod = 34'(hu_reg[0]) * 34'(hu_reg[1]);

    always_ff @(posedge aclk) begin
        if (en) begin
            wave_reg <= wave_prod[32:16];
            cr_reg   <= hu_reg[2];
            cg_reg   <= hu_reg[3];
            cb_reg   <= hu_reg[4];
        end
    end

    vtpg_pkg::color_t wave_col_reg;
    logic [33:0]      wr_prod;
    logic [33:0]      wg_prod;
    logic [16:0]      wave_inv;

    assign wave_inv = 17'(18'd65536 - 18'(wave_reg));
    assign wr_prod  = 34'(cr_reg) * 34'(wave_reg);
    assign wg_prod  = 34'(cg_reg) * 34'(wave_inv);

    always_ff @(posedge aclk) begin
        if (en) begin
            wave_col_reg.red   <= wr_prod[32:16];
            wave_col_reg.green <= wg_prod[32:16];
            wave_col_reg.blue  <= cb_reg;
        end
    end

    // ---------------- colour wheel ----------------

    // centre offset, squared radius and vectoring start
    logic signed [16:0] cx;
    logic signed [16:0] cy;
    logic [31:0]        sq_sum;
    logic signed [33:0] cx_sq;
    logic signed [33:0] cy_sq;

    assign cx     = $signed({1'b0, nx}) - 17'sd32768;
    assign cy     = $signed({1'b0, ny}) - 17'sd32768;
    assign cx_sq  = 34'(cx) * 34'(cx);
    assign cy_sq  = 34'(cy) * 34'(cy);
    assign sq_sum = 32'(cx_sq + cy_sq);

    logic [31:0]          sq_reg;
    logic signed [VW-1:0] vx [0:STEPS];
    logic signed [VW-1:0] vy [0:STEPS];
    logic [15:0]          vz [0:STEPS];
    logic signed [VW-1:0] vx0_reg;
    logic signed [VW-1:0] vy0_reg;
    logic [15:0]          vz0_reg;
    logic [STEPS:0]       zero_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg <= sq_sum;
            if (cx < 0) begin
                vx0_reg <= -(VW'(cx) <<< 8);
                vy0_reg <= -(VW'(cy) <<< 8);
                vz0_reg <= 16'h8000;
            end else begin
                vx0_reg <= VW'(cx) <<< 8;
                vy0_reg <= VW'(cy) <<< 8;
                vz0_reg <= 16'h0000;
            end
            zero_reg <= {zero_reg[STEPS-1:0], (cx == 17'sd0) && (cy == 17'sd0)};
        end
    end

    assign vx[0] = vx0_reg;
    assign vy[0] = vy0_reg;
    assign vz[0] = vz0_reg;

    for (genvar k = 0; k < STEPS; k++) begin : g_vec
        vtpg_vec_cell #(.STEP(k)) u_vec (
            .aclk  (aclk),
            .en    (en),
            .x_in  (vx[k]),
            .y_in  (vy[k]),
            .z_in  (vz[k]),
            .x_out (vx[k+1]),
            .y_out (vy[k+1]),
            .z_out (vz[k+1])
        );
    end

    // floor square root, one bit per cell
    logic [31:0] sv  [0:16];
    logic [16:0] srm [0:16];
    logic [15:0] srt [0:16];

    assign sv[0]  = sq_reg;
    assign srm[0] = 17'd0;
    assign srt[0] = 16'd0;

    for (genvar k = 0; k < 16; k++) begin : g_sqrt
        vtpg_sqrt_cell u_sqrt (
            .aclk     (aclk),
            .en       (en),
            .val_in   (sv[k]),
            .rem_in   (srm[k]),
            .root_in  (srt[k]),
            .val_out  (sv[k+1]),
            .rem_out  (srm[k+1]),
            .root_out (srt[k+1])
        );
    end

    // hue, sector and fraction; the centre pixel takes angle zero
    logic [15:0] hue;
    logic [18:0] h6;
    logic [2:0]  sec1_reg;
    logic [15:0] f_reg;

    assign hue = (zero_reg[STEPS] ? 16'd0 : vz[STEPS]) + 16'h8000;
    assign h6  = 19'(hue) * 19'd6;

    always_ff @(posedge aclk) begin
        if (en) begin
            sec1_reg <= h6[18:16];
            f_reg    <= h6[15:0];
        end
    end

    // saturation terms and p
    logic signed [17:0] sat;
    logic [16:0]        one_m_s;
    logic [16:0]        one_m_f;
    logic signed [34:0] fs_prod;
    logic signed [35:0] fs2_prod;
    logic [32:0]        p_prod;
    logic signed [19:0] fs_reg;
    logic signed [19:0] fs2_reg;
    logic [16:0]        p_reg;
    logic [2:0]         sec2_reg;

    assign sat      = 18'sd65536 - $signed({1'b0, srt[16], 1'b0});
    assign one_m_s  = 17'(19'sd65536 - 19'(sat));
    assign one_m_f  = 17'(18'd65536 - 18'(f_reg));
    assign fs_prod  = 35'($signed({1'b0, f_reg})) * 35'(sat);
    assign fs2_prod = 36'($signed({1'b0, one_m_f})) * 36'(sat);
    assign p_prod   = 33'(vtpg_pkg::VALUE_Q16) * 33'(one_m_s);

    always_ff @(posedge aclk) begin
        if (en) begin
            fs_reg   <= 20'(fs_prod >>> 16);
            fs2_reg  <= 20'(fs2_prod >>> 16);
            p_reg    <= p_prod[32:16];
            sec2_reg <= sec1_reg;
        end
    end

    // q and t
    logic [16:0] q_fac;
    logic [16:0] t_fac;
    logic [32:0] q_prod;
    logic [32:0] t_prod;
    logic [16:0] q_reg;
    logic [16:0] t_reg;
    logic [16:0] p2_reg;
    logic [2:0]  sec3_reg;

    assign q_fac  = 17'(20'sd65536 - fs_reg);
    assign t_fac  = 17'(20'sd65536 - fs2_reg);
    assign q_prod = 33'(vtpg_pkg::VALUE_Q16) * 33'(q_fac);
    assign t_prod = 33'(vtpg_pkg::VALUE_Q16) * 33'(t_fac);

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg    <= q_prod[32:16];
            t_reg    <= t_prod[32:16];
            p2_reg   <= p_reg;
            sec3_reg <= sec2_reg;
        end
    end

    // sector select
    vtpg_pkg::color_t wheel_col_reg;
    vtpg_pkg::color_t wheel_col;
    logic [16:0]      val_w;

    assign val_w = 17'(vtpg_pkg::VALUE_Q16);

    always_comb begin
        unique case (sec3_reg)
            3'd0:    wheel_col = '{red: val_w, green: t_reg, blue: p2_reg};
            3'd1:    wheel_col = '{red: q_reg, green: val_w, blue: p2_reg};
            3'd2:    wheel_col = '{red: p2_reg, green: val_w, blue: t_reg};
            3'd3:    wheel_col = '{red: p2_reg, green: q_reg, blue: val_w};
            3'd4:    wheel_col = '{red: t_reg, green: p2_reg, blue: val_w};
            default: wheel_col = '{red: val_w, green: p2_reg, blue: q_reg};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            wheel_col_reg <= wheel_col;
        end
    end

    // ---------------- output ----------------

    vtpg_pkg::color_t col;
    logic [23:0]      pix;
    logic [23:0]      out_reg;
    logic [23:0]      skid_reg;
    logic             m_valid_reg;

    assign col = paused_reg ? wheel_col_reg : wave_col_reg;
    assign pix = {to_byte(col.red), to_byte(col.green), to_byte(col.blue)};

    // output register with a skid stage behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (en && vld_reg[LAST]) begin
            if (m_valid_reg && !m_ready) begin
                skid_vld_reg <= 1'b1;
            end else begin
                m_valid_reg <= 1'b1;
            end
        end else if (m_ready) begin
            if (skid_vld_reg) begin
                skid_vld_reg <= 1'b0;
            end else begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en && vld_reg[LAST]) begin
            if (m_valid_reg && !m_ready) begin
                skid_reg <= pix;
            end else begin
                out_reg <= pix;
            end
        end else if (m_ready && skid_vld_reg) begin
            out_reg <= skid_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_red   = out_reg[23:16];
    assign m_green = out_reg[15:8];
    assign m_blue  = out_reg[7:0];
    assign m_alpha = 8'd255;

endmodule

`default_nettype wire
